// ----- design/ordered_list_insert_delete_defines.svh -----
// Assertion macros used by the ordered list top level.
// Depends on nothing; include by bare file name.
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olid: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olid: next-cycle check failed");

`endif

// ----- design/olid_pkg.sv -----
// Package for the ordered list block: sizes, codes, transaction and cell control types.
// Depends on nothing.
package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > 6) ? CNT_W : 6) + 1;

    typedef enum logic [2:0] {
        ACT_INS_END   = 3'd0,
        ACT_INS_FRONT = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_END   = 3'd3,
        ACT_DEL_FRONT = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_READ      = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_action            action;
        logic signed [31:0] value;
        logic [5:0]         position;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] element;
        logic [5:0]         element_index;
        logic [6:0]         length;
        logic               last;
    } t_result;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   wrap;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

// ----- design/olid_cell.sv -----
// One storage cell of the ordered list chain.
// Depends on olid_pkg.
module olid_cell (
    input  logic                      i_clk,
    input  olid_pkg::t_cell_ctl       i_ctl,
    input  logic [olid_pkg::IDX_W-1:0] i_idx,
    input  logic signed [31:0]        i_left,
    input  logic signed [31:0]        i_right,
    input  logic signed [31:0]        i_head,
    output logic signed [31:0]        o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            olid_pkg::OP_INS: begin
                if (i_idx == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end else if (i_idx > i_ctl.pos) begin
                    n_data = i_left;
                end
            end
            olid_pkg::OP_DEL: begin
                if (i_idx >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            olid_pkg::OP_ROT: begin
                // close the ring at the tail: the tail takes the head
                n_data = (i_idx == i_ctl.wrap) ? i_head : i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- design/ordered_list_insert_delete.sv -----
// Top level of the ordered list: command decode, read-out sequencer, chain of cells.
// Depends on olid_pkg, olid_cell and ordered_list_insert_delete_defines.svh.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------
//  command   | start in, busy out         | i_item   (olid_pkg::t_item)
//  result    | o_valid out, no back-press | o_result (olid_pkg::t_result)
//
// Insert, delete and no-op commands leave busy low, so a new command may
// follow in every cycle and its result shows in the next cycle.
// A read out of n elements holds busy while the ring rotates once through
// cell 0, one element per cycle; an empty list gives one result.
// Synchronous active-low reset empties the list; cell contents are not reset.
// The receiver cannot stall: each result stands for exactly one cycle.
`include "ordered_list_insert_delete_defines.svh"

module ordered_list_insert_delete (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  olid_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_valid,
    output olid_pkg::t_result o_result
);

    localparam int IDX_W = olid_pkg::IDX_W;
    localparam int CNT_W = olid_pkg::CNT_W;
    localparam int CMP_W = olid_pkg::CMP_W;

    // control state
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_rd_active;
    logic              n_rd_active;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  n_rd_idx;
    logic              r_valid;
    logic              n_valid;
    olid_pkg::t_result r_result;
    olid_pkg::t_result n_result;

    olid_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic [CMP_W-1:0]   w_pos_ext;
    logic               w_full;
    logic               w_empty;
    logic [IDX_W:0]     w_rd_next;
    logic [IDX_W-1:0]   w_tail;
    logic signed [31:0] w_data [olid_pkg::CAPACITY];

    assign w_accept  = start && !r_rd_active;
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_pos_ext = CMP_W'(i_item.position);
    assign w_full    = (r_count == CNT_W'(olid_pkg::CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_rd_next = {1'b0, r_rd_idx} + 1'b1;
    assign w_tail    = IDX_W'(r_count - 1'b1);

    // Decode the command, or advance the read out.
    always_comb begin
        n_count     = r_count;
        n_rd_active = r_rd_active;
        n_rd_idx    = r_rd_idx;
        n_valid     = 1'b0;
        n_result    = '0;
        w_ctl       = '0;
        w_ctl.op    = olid_pkg::OP_HOLD;
        w_ctl.value = i_item.value;
        w_ctl.wrap  = w_tail;

        if (r_rd_active) begin
            // rotate the ring one step and emit the head element
            w_ctl.op               = olid_pkg::OP_ROT;
            n_valid                = 1'b1;
            n_result.status        = olid_pkg::ST_OK;
            n_result.element       = w_data[0];
            n_result.element_index = 6'(w_rd_next);
            n_result.length        = 7'(r_count);
            n_result.last          = (r_rd_idx == w_tail);
            n_rd_idx               = IDX_W'(w_rd_next);
            if (r_rd_idx == w_tail) begin
                n_rd_active = 1'b0;
            end
        end else if (w_accept) begin
            n_valid         = 1'b1;
            n_result.status = olid_pkg::ST_OK;
            n_result.last   = 1'b1;
            case (i_item.action)
                olid_pkg::ACT_INS_END, olid_pkg::ACT_INS_FRONT,
                olid_pkg::ACT_INS_POS: begin
                    if (w_full) begin
                        n_result.status = olid_pkg::ST_FULL;
                    end else if (i_item.action == olid_pkg::ACT_INS_POS &&
                                 (w_pos_ext == '0 || w_pos_ext > w_cnt_ext + 1'b1)) begin
                        n_result.status = olid_pkg::ST_INVALID;
                    end else begin
                        w_ctl.op = olid_pkg::OP_INS;
                        if (i_item.action == olid_pkg::ACT_INS_END) begin
                            w_ctl.pos = IDX_W'(r_count);
                        end else if (i_item.action == olid_pkg::ACT_INS_FRONT) begin
                            w_ctl.pos = '0;
                        end else begin
                            w_ctl.pos = IDX_W'(w_pos_ext - 1'b1);
                        end
                        n_count = r_count + 1'b1;
                    end
                end
                olid_pkg::ACT_DEL_END, olid_pkg::ACT_DEL_FRONT,
                olid_pkg::ACT_DEL_POS: begin
                    if (w_empty) begin
                        n_result.status = olid_pkg::ST_EMPTY;
                    end else if (i_item.action == olid_pkg::ACT_DEL_POS &&
                                 (w_pos_ext == '0 || w_pos_ext > w_cnt_ext)) begin
                        n_result.status = olid_pkg::ST_INVALID;
                    end else begin
                        w_ctl.op = olid_pkg::OP_DEL;
                        if (i_item.action == olid_pkg::ACT_DEL_END) begin
                            w_ctl.pos = w_tail;
                        end else if (i_item.action == olid_pkg::ACT_DEL_FRONT) begin
                            w_ctl.pos = '0;
                        end else begin
                            w_ctl.pos = IDX_W'(w_pos_ext - 1'b1);
                        end
                        n_count = r_count - 1'b1;
                    end
                end
                olid_pkg::ACT_READ: begin
                    // empty list: one closing transaction now; otherwise start rotation
                    if (!w_empty) begin
                        n_valid     = 1'b0;
                        n_rd_active = 1'b1;
                        n_rd_idx    = '0;
                    end
                end
                default: begin
                    // unused code: report the length, change nothing
                end
            endcase
            n_result.length = 7'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_active <= 1'b0;
            r_rd_idx    <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_active <= n_rd_active;
            r_rd_idx    <= n_rd_idx;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Chain of cells: on insert, cells past the position take their left neighbor; on
    // delete from the position on, and on rotation, their right; cell 0 feeds the tail.
    genvar g;
    generate
        for (g = 0; g < olid_pkg::CAPACITY; g++) begin : g_cell
            logic signed [31:0] w_left;
            logic signed [31:0] w_right;
            if (g == 0) begin : g_head
                assign w_left = i_item.value;
            end else begin : g_body
                assign w_left = w_data[g-1];
            end
            if (g == olid_pkg::CAPACITY - 1) begin : g_end
                assign w_right = w_data[g];
            end else begin : g_mid
                assign w_right = w_data[g+1];
            end
            olid_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_idx   (IDX_W'(g)),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_data[0]),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    assign busy     = r_rd_active;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // every accepted transaction answers in the following cycle, except a
    // read out of a non-empty list, which answers once the read-out state is registered
    `OLID_ASSERT_NXT(a_accept_answers, i_clk, i_rst_n,
        w_accept && !(i_item.action == olid_pkg::ACT_READ && !w_empty), o_valid && o_result.last)
    // a read out in progress never runs on an empty list
    `OLID_ASSERT_IMP(a_read_nonempty, i_clk, i_rst_n, r_rd_active, !w_empty)
    // read-out transactions come back to back until the last one
    `OLID_ASSERT_NXT(a_read_contiguous, i_clk, i_rst_n, o_valid && !o_result.last, o_valid)
    // a non-final transaction is only shown while the read out still holds busy
    `OLID_ASSERT_IMP(a_busy_mid_read, i_clk, i_rst_n, o_valid && !o_result.last, busy)
    // the count never exceeds the capacity
    `OLID_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(olid_pkg::CAPACITY))

endmodule

// ----- test/tb_ordered_list_insert_delete.sv -----
// Self-checking testbench for ordered_list_insert_delete: directed table, then random bursts.
// Depends on olid_pkg and the ordered_list_insert_delete RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete;
    import olid_pkg::*;

    // Code 7 is not an action of the block; it must act as a no-op.
    localparam logic [2:0] ACT_UNUSED   = 3'd7;
    localparam int         DIR_ROWS     = 25;
    localparam int         RAND_ITEMS   = 310;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 40;

    // Burst kinds of the random part.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    typedef struct {
        t_item   item;
        int      reps;      // row is sent this many times, value stepping by one
        bit      has_exp;   // expected result typed into the table
        t_result exp_res;
    } dir_row_t;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    // Typed expectation travels with the transaction, so it is sampled at the same edge.
    logic    typed_on  = 1'b0;
    t_result typed_res = '0;

    // Predicted list contents and the results still owed by the block.
    logic signed [31:0] list_vals [CAPACITY];
    int                 list_len = 0;
    t_result            owed_results [$];

    int       mismatch_count = 0;
    int       quiet_cycles   = 0;
    int       idle_pct       = 0;
    dir_row_t dir_table [DIR_ROWS];

    ordered_list_insert_delete dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Build one result word with no element attached.
    function automatic t_result status_word(t_status st, int len);
        t_result r;
        r        = '0;
        r.status = st;
        r.length = 7'(len);
        r.last   = 1'b1;
        return r;
    endfunction

    // Apply one accepted command to the predicted list and return the results it causes.
    function automatic void list_apply(input t_item it, ref t_result res_q[$]);
        int      p;
        t_status st;
        t_result r;
        st = ST_OK;
        p  = 0;
        res_q.delete();
        if (it.action == ACT_READ) begin
            if (list_len == 0) begin
                res_q.push_back(status_word(ST_OK, 0));
            end else begin
                for (int i = 0; i < list_len; i++) begin
                    r               = '0;
                    r.status        = ST_OK;
                    r.element       = list_vals[i];
                    r.element_index = 6'(i + 1);
                    r.length        = 7'(list_len);
                    r.last          = (i + 1 == list_len);
                    res_q.push_back(r);
                end
            end
            return;
        end
        case (it.action)
            ACT_INS_END, ACT_INS_FRONT, ACT_INS_POS: begin
                if (it.action == ACT_INS_END)        p = list_len + 1;
                else if (it.action == ACT_INS_FRONT) p = 1;
                else                                 p = int'(it.position);
                // Full is checked ahead of the position.
                if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    st = ST_INVALID;
                end else begin
                    for (int i = list_len; i >= p; i--) list_vals[i] = list_vals[i-1];
                    list_vals[p-1] = it.value;
                    list_len++;
                end
            end
            ACT_DEL_END, ACT_DEL_FRONT, ACT_DEL_POS: begin
                if (it.action == ACT_DEL_END)        p = list_len;
                else if (it.action == ACT_DEL_FRONT) p = 1;
                else                                 p = int'(it.position);
                // Empty is checked ahead of the position.
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (p < 1 || p > list_len) begin
                    st = ST_INVALID;
                end else begin
                    for (int i = p; i < list_len; i++) list_vals[i-1] = list_vals[i];
                    list_len--;
                end
            end
            default: ;  // unused code: leave the list alone
        endcase
        res_q.push_back(status_word(st, list_len));
    endfunction

    // Compare one result against the oldest one still owed, field by field.
    task automatic check_result(t_result got);
        t_result want;
        if (owed_results.size() == 0) begin
            $error("result with nothing expected: status %0d length %0d",
                   got.status, got.length);
            mismatch_count++;
            return;
        end
        want = owed_results.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, got.element);
            mismatch_count++;
        end
        if (got.element_index !== want.element_index) begin
            $error("element_index: expected %0d, actual %0d",
                   want.element_index, got.element_index);
            mismatch_count++;
        end
        if (got.length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, got.length);
            mismatch_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatch_count++;
        end
    endtask

    // Monitor: check results first, then predict the transaction taken at this edge.
    // Both read pre-edge values, so ordering against the block's own logic does not matter.
    always @(posedge i_clk) begin
        t_result fresh [$];
        if (i_rst_n) begin
            if (o_valid === 1'b1) check_result(o_result);
            if (start && busy === 1'b0) begin
                list_apply(i_item, fresh);
                // A typed row replaces the prediction; the list state still advances.
                if (typed_on) begin
                    fresh.delete();
                    fresh.push_back(typed_res);
                end
                foreach (fresh[k]) owed_results.push_back(fresh[k]);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic dir_row_t dir_row(logic [2:0] act, logic [31:0] val, logic [5:0] pos,
                                         int reps, bit has_exp, t_status st, int len);
        dir_row_t r;
        r.item.action   = t_action'(act);
        r.item.value    = val;
        r.item.position = pos;
        r.reps          = reps;
        r.has_exp       = has_exp;
        r.exp_res       = status_word(st, len);
        return r;
    endfunction

    // Pick one random command; the burst kind leans toward filling or draining the list.
    function automatic t_item rand_item(int mode);
        t_item it;
        int    roll;
        roll = $urandom_range(0, 99);
        it.value = $urandom();
        // Mostly positions near the list, sometimes anything the field can hold.
        it.position = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(1, CAPACITY + 1))
                                                   : 6'($urandom_range(0, 63));
        if (roll < 8) begin
            it.action = ACT_READ;
        end else if (roll < 11) begin
            it.action = t_action'(ACT_UNUSED);
        end else begin
            roll = $urandom_range(0, 99);
            if ((mode == MODE_FILL && roll < 80) || (mode == MODE_DRAIN && roll < 20) ||
                (mode == MODE_MIX && roll < 50))
                it.action = t_action'($urandom_range(ACT_INS_END, ACT_INS_POS));
            else
                it.action = t_action'($urandom_range(ACT_DEL_END, ACT_DEL_POS));
        end
        return it;
    endfunction

    // Present one transaction and hold it until the block takes it, then maybe go idle.
    task automatic send_item(t_item it, bit has_exp, t_result exp_res);
        start     <= 1'b1;
        i_item    <= it;
        typed_on  <= has_exp;
        typed_res <= exp_res;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            start    <= 1'b0;
            typed_on <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    initial begin
        // Sender idle percentage per random phase; the receiver cannot stall,
        // so the receiver phases reduce to their sender share.
        int      phase_idle [4];
        int      mode;
        int      burst_left;
        t_item   it;
        phase_idle = '{0, 59, 0, 34};
        mode       = MODE_FILL;
        burst_left = 0;

        // Directed table: empty-list cases, extremes, bad positions, then a full list.
        dir_table[0]  = dir_row(ACT_READ,      32'h0,        6'd0,  1,  1, ST_OK,      0);
        dir_table[1]  = dir_row(ACT_DEL_END,   32'h0,        6'd0,  1,  1, ST_EMPTY,   0);
        dir_table[2]  = dir_row(ACT_DEL_FRONT, 32'hFFFFFFFF, 6'd1,  1,  1, ST_EMPTY,   0);
        dir_table[3]  = dir_row(ACT_DEL_POS,   32'h0,        6'd63, 1,  1, ST_EMPTY,   0);
        dir_table[4]  = dir_row(ACT_INS_POS,   32'h5,        6'd0,  1,  1, ST_INVALID, 0);
        dir_table[5]  = dir_row(ACT_INS_POS,   32'h5,        6'd2,  1,  1, ST_INVALID, 0);
        dir_table[6]  = dir_row(ACT_INS_END,   32'h7FFFFFFF, 6'd0,  1,  1, ST_OK,      1);
        dir_table[7]  = dir_row(ACT_INS_FRONT, 32'h80000000, 6'd63, 1,  1, ST_OK,      2);
        dir_table[8]  = dir_row(ACT_INS_POS,   32'hFFFFFFFF, 6'd3,  1,  1, ST_OK,      3);
        dir_table[9]  = dir_row(ACT_INS_POS,   32'h0,        6'd2,  1,  1, ST_OK,      4);
        dir_table[10] = dir_row(ACT_UNUSED,    32'hA5A5A5A5, 6'd2,  1,  1, ST_OK,      4);
        dir_table[11] = dir_row(ACT_READ,      32'h0,        6'd0,  1,  0, ST_OK,      0);
        dir_table[12] = dir_row(ACT_DEL_POS,   32'h0,        6'd0,  1,  1, ST_INVALID, 4);
        dir_table[13] = dir_row(ACT_DEL_POS,   32'h0,        6'd5,  1,  1, ST_INVALID, 4);
        dir_table[14] = dir_row(ACT_INS_POS,   32'h1,        6'd6,  1,  1, ST_INVALID, 4);
        dir_table[15] = dir_row(ACT_DEL_POS,   32'h0,        6'd2,  1,  1, ST_OK,      3);
        dir_table[16] = dir_row(ACT_DEL_END,   32'h0,        6'd0,  1,  1, ST_OK,      2);
        dir_table[17] = dir_row(ACT_DEL_FRONT, 32'h0,        6'd0,  1,  1, ST_OK,      1);
        dir_table[18] = dir_row(ACT_READ,      32'h0,        6'd0,  1,  0, ST_OK,      0);
        dir_table[19] = dir_row(ACT_INS_END,   32'h100,      6'd0,  15, 0, ST_OK,      0);
        dir_table[20] = dir_row(ACT_INS_END,   32'h1,        6'd0,  1,  1, ST_FULL,    16);
        dir_table[21] = dir_row(ACT_INS_FRONT, 32'h1,        6'd0,  1,  1, ST_FULL,    16);
        dir_table[22] = dir_row(ACT_INS_POS,   32'h1,        6'd63, 1,  1, ST_FULL,    16);
        dir_table[23] = dir_row(ACT_READ,      32'h0,        6'd0,  1,  0, ST_OK,      0);
        dir_table[24] = dir_row(ACT_DEL_POS,   32'h0,        6'd16, 1,  1, ST_OK,      15);

        // Hold reset low from the start, then release it at a rising edge.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table with no idling.
        foreach (dir_table[r]) begin
            for (int k = 0; k < dir_table[r].reps; k++) begin
                it       = dir_table[r].item;
                it.value = it.value + k;
                send_item(it, dir_table[r].has_exp, dir_table[r].exp_res);
            end
        end

        // Random part in four phases of sender idling; bursts lean toward fill or drain.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_pct = phase_idle[(n * 4) / RAND_ITEMS];
            if (burst_left == 0) begin
                mode       = $urandom_range(MODE_FILL, MODE_MIX);
                burst_left = $urandom_range(8, 28);
            end
            burst_left--;
            send_item(rand_item(mode), 1'b0, '0);
        end

        // Drop start, wait for every owed result, then watch for strays.
        start    <= 1'b0;
        typed_on <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
